// ----- hdl/ossc_pkg.sv -----
// Shared types, constants and the control-store program of the speed and steer conditioner.
`timescale 1ns / 1ps
`default_nettype none

package ossc_pkg;

    localparam int unsigned PC_W = 4;
    localparam int unsigned RING_DEPTH = 3;

    localparam logic [16:0] ONE_Q15  = 17'd32768;
    localparam logic [33:0] HALF_Q15 = 34'd16384;
    localparam logic signed [15:0] YAW_LIMIT = 16'sd23040;
    localparam logic signed [18:0] SPEED_MAX = 19'sd32767;

    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_UNLOCKED = 2'd1;
    localparam logic [1:0] MODE_STOPPING = 2'd2;

    localparam logic [2:0] CFG_SPEED_SMOOTHING = 3'd0;
    localparam logic [2:0] CFG_TURN_SMOOTHING  = 3'd1;
    localparam logic [2:0] CFG_SPEED_LIMIT     = 3'd2;
    localparam logic [2:0] CFG_TURN_GAIN       = 3'd3;
    localparam logic [2:0] CFG_HOVER_HEIGHT    = 3'd4;

    localparam logic [15:0] RST_SPEED_SMOOTHING = 16'd22938;
    localparam logic [15:0] RST_TURN_SMOOTHING  = 16'd16384;
    localparam logic [14:0] RST_SPEED_LIMIT     = 15'd3277;
    localparam logic [14:0] RST_TURN_GAIN       = 15'd15360;
    localparam logic [11:0] RST_HOVER_HEIGHT    = 12'd300;

    localparam logic [PC_W-1:0] STOP_ADDR = PC_W'(9);

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        M_GAIN_STEER,
        M_LIMIT_MED,
        M_TURN_WB,
        M_TGT_B,
        M_SPEED_WA,
        M_TGT_A
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_MED,
        D_TGT_SAT,
        D_TGT,
        D_TURN,
        D_SPEED
    } dst_t;

    typedef enum logic {
        BR_NEXT,
        BR_IF_STOP
    } br_t;

    typedef struct packed {
        mul_sel_t mul;
        acc_op_t  acc;
        dst_t     dst;
        br_t      br;
        logic     last;
        logic     stop_out;
    } ctrl_word_t;

    // what the top level hands the datapath when an item is taken
    typedef struct packed {
        logic               latch_steer;
        logic               write_ring;
        logic [15:0]        collision;
        logic signed [15:0] steer;
    } item_load_t;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        w = '{mul: M_GAIN_STEER, acc: ACC_HOLD, dst: D_NONE, br: BR_NEXT,
              last: 1'b1, stop_out: 1'b0};
        case (addr)
            PC_W'(0): w = '{M_GAIN_STEER, ACC_HOLD, D_MED,     BR_IF_STOP, 1'b0, 1'b0};
            PC_W'(1): w = '{M_LIMIT_MED,  ACC_LOAD, D_NONE,    BR_NEXT,    1'b0, 1'b0};
            PC_W'(2): w = '{M_TURN_WB,    ACC_LOAD, D_TGT_SAT, BR_NEXT,    1'b0, 1'b0};
            PC_W'(3): w = '{M_TGT_B,      ACC_LOAD, D_TGT,     BR_NEXT,    1'b0, 1'b0};
            PC_W'(4): w = '{M_SPEED_WA,   ACC_ADD,  D_NONE,    BR_NEXT,    1'b0, 1'b0};
            PC_W'(5): w = '{M_TGT_A,      ACC_LOAD, D_TURN,    BR_NEXT,    1'b0, 1'b0};
            PC_W'(6): w = '{M_TGT_A,      ACC_ADD,  D_NONE,    BR_NEXT,    1'b0, 1'b0};
            PC_W'(7): w = '{M_TGT_A,      ACC_HOLD, D_SPEED,   BR_NEXT,    1'b0, 1'b0};
            PC_W'(8): w = '{M_TGT_A,      ACC_HOLD, D_NONE,    BR_NEXT,    1'b1, 1'b0};
            STOP_ADDR: w = '{M_TGT_A,     ACC_HOLD, D_NONE,    BR_NEXT,    1'b1, 1'b1};
            default: w = '{M_GAIN_STEER,  ACC_HOLD, D_NONE,    BR_NEXT,    1'b1, 1'b0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/obstacle_speed_steer_conditioner.sv -----
// An unlocked item gives its setpoint on its last control-store step after it is accepted,
// a stopping item on its stop step; an idle item is absorbed with no result.
// The input stays closed while an item runs (nine control-store steps run both filters
// through the single shared 17x17 multiplier); the last step waits while a result is unread.
// Reset (aresetn low, synchronous): ring, filter state and sequencer clear, registers
// take their defaults, no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module obstacle_speed_steer_conditioner (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // collision [15:0], steer_in [31:16]
    input  wire logic [2:0]  s_tuser,   // flight_mode [1:0], sample_valid [2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // forward_speed [14:0], yaw_rate_out [30:15],
                                        // height_out [42:31], zero fill [47:43]
    output logic             m_tuser,   // stop_setpoint
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0] speed_smoothing_reg;
    logic [15:0] turn_smoothing_reg;
    logic [14:0] speed_limit_reg;
    logic [14:0] turn_gain_reg;
    logic [11:0] hover_height_reg;

    logic               m_tvalid_reg;
    logic               stop_reg;
    logic [14:0]        speed_o_reg;
    logic signed [15:0] yaw_o_reg;
    logic [11:0]        height_o_reg;

    logic [1:0]           mode;
    logic                 s_accept;
    logic                 start;
    logic                 out_hold;
    logic                 step_en;
    logic                 busy;
    ossc_pkg::ctrl_word_t ctrl;
    ossc_pkg::item_load_t load;
    logic [14:0]          speed_now;
    logic signed [15:0]   turn_now;

    assign mode     = s_tuser[1:0];
    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;
    assign start    = s_accept &&
                      (mode == ossc_pkg::MODE_UNLOCKED || mode == ossc_pkg::MODE_STOPPING);
    assign out_hold = m_tvalid_reg && !m_tready;

    always_comb begin
        load.latch_steer = start;
        load.write_ring  = s_accept && mode == ossc_pkg::MODE_UNLOCKED && s_tuser[2];
        load.collision   = s_tdata[15:0];
        // steer counts as zero on ticks without a new sample
        load.steer       = s_tuser[2] ? signed'(s_tdata[31:16]) : '0;
    end

    ossc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_stop (mode == ossc_pkg::MODE_STOPPING),
        .out_hold   (out_hold),
        .ctrl       (ctrl),
        .step_en    (step_en),
        .busy       (busy)
    );

    ossc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load),
        .ctrl            (ctrl),
        .step_en         (step_en),
        .speed_smoothing (speed_smoothing_reg),
        .turn_smoothing  (turn_smoothing_reg),
        .speed_limit     (speed_limit_reg),
        .turn_gain       (turn_gain_reg),
        .speed_out       (speed_now),
        .turn_out        (turn_now)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_smoothing_reg <= ossc_pkg::RST_SPEED_SMOOTHING;
            turn_smoothing_reg  <= ossc_pkg::RST_TURN_SMOOTHING;
            speed_limit_reg     <= ossc_pkg::RST_SPEED_LIMIT;
            turn_gain_reg       <= ossc_pkg::RST_TURN_GAIN;
            hover_height_reg    <= ossc_pkg::RST_HOVER_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                ossc_pkg::CFG_SPEED_SMOOTHING: speed_smoothing_reg <= cfg_wdata;
                ossc_pkg::CFG_TURN_SMOOTHING:  turn_smoothing_reg  <= cfg_wdata;
                ossc_pkg::CFG_SPEED_LIMIT:     speed_limit_reg     <= cfg_wdata[14:0];
                ossc_pkg::CFG_TURN_GAIN:       turn_gain_reg       <= cfg_wdata[14:0];
                ossc_pkg::CFG_HOVER_HEIGHT:    hover_height_reg    <= cfg_wdata[11:0];
                default: begin
                end
            endcase
        end
    end

    // result register: load on the final program step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (step_en && ctrl.last) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && ctrl.last) begin
            stop_reg     <= ctrl.stop_out;
            speed_o_reg  <= ctrl.stop_out ? '0 : speed_now;
            yaw_o_reg    <= ctrl.stop_out ? '0 : turn_now;
            height_o_reg <= ctrl.stop_out ? '0 : hover_height_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = stop_reg;
    assign m_tdata  = {5'b00000, height_o_reg, yaw_o_reg, speed_o_reg};

endmodule

`default_nettype wire

// ----- hdl/ossc_seq.sv -----
// Step counter and control-store sequencer of the conditioner.
`timescale 1ns / 1ps
`default_nettype none

module ossc_seq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic                  start_stop,
    input  wire logic                  out_hold,
    output ossc_pkg::ctrl_word_t       ctrl,
    output logic                       step_en,
    output logic                       busy
);

    logic [ossc_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                      busy_reg, busy_next;
    logic                      stop_reg, stop_next;

    assign ctrl    = ossc_pkg::ucode(pc_reg);
    // hold on the final step while the result register is still occupied
    assign step_en = busy_reg && !(ctrl.last && out_hold);
    assign busy    = busy_reg;

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        stop_next = stop_reg;
        if (start && !busy_reg) begin
            pc_next   = '0;
            busy_next = 1'b1;
            stop_next = start_stop;
        end else if (step_en) begin
            if (ctrl.last) begin
                busy_next = 1'b0;
            end else if (ctrl.br == ossc_pkg::BR_IF_STOP && stop_reg) begin
                pc_next = ossc_pkg::STOP_ADDR;
            end else begin
                pc_next = pc_reg + ossc_pkg::PC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            busy_reg <= 1'b0;
            stop_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
            stop_reg <= stop_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ossc_dp.sv -----
// Datapath: collision ring, median, shared multiplier, accumulator and filter state.
`timescale 1ns / 1ps
`default_nettype none

module ossc_dp (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ossc_pkg::item_load_t  load,
    input  wire ossc_pkg::ctrl_word_t  ctrl,
    input  wire logic                  step_en,
    input  wire logic [15:0]           speed_smoothing,
    input  wire logic [15:0]           turn_smoothing,
    input  wire logic [14:0]           speed_limit,
    input  wire logic [14:0]           turn_gain,
    output logic [14:0]                speed_out,
    output logic signed [15:0]         turn_out
);

    localparam int unsigned SLOT_W =
        (ossc_pkg::RING_DEPTH > 1) ? $clog2(ossc_pkg::RING_DEPTH) : 1;

    logic [15:0]        ring_reg [ossc_pkg::RING_DEPTH];
    logic [SLOT_W-1:0]  slot_reg;
    logic [14:0]        speed_reg;
    logic signed [15:0] turn_reg;
    logic signed [15:0] steer_reg;
    logic [15:0]        med_reg;
    logic signed [15:0] tgt_reg;
    logic signed [33:0] prod_reg;
    logic signed [33:0] acc_reg;

    logic [15:0]        coll_sat;
    logic [16:0]        wa, wb;
    logic signed [16:0] op_a, op_b;
    logic signed [18:0] scaled;
    logic [15:0]        med_now;

    function automatic logic [15:0] median3(input logic [15:0] p, input logic [15:0] q,
                                            input logic [15:0] r);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        if (r <= lo) begin
            return lo;
        end else if (r >= hi) begin
            return hi;
        end
        return r;
    endfunction

    function automatic logic [16:0] clamp_w(input logic [15:0] w);
        return ({1'b0, w} > ossc_pkg::ONE_Q15) ? ossc_pkg::ONE_Q15 : {1'b0, w};
    endfunction

    function automatic logic signed [15:0] sat_yaw(input logic signed [18:0] v);
        if (v > 19'(ossc_pkg::YAW_LIMIT)) begin
            return ossc_pkg::YAW_LIMIT;
        end else if (v < -19'(ossc_pkg::YAW_LIMIT)) begin
            return -ossc_pkg::YAW_LIMIT;
        end
        return v[15:0];
    endfunction

    function automatic logic [14:0] sat_speed(input logic signed [18:0] v);
        if (v[18]) begin
            return '0;
        end else if (v > ossc_pkg::SPEED_MAX) begin
            return 15'h7FFF;
        end
        return v[14:0];
    endfunction

    assign coll_sat = ({1'b0, load.collision} > ossc_pkg::ONE_Q15) ?
                      ossc_pkg::ONE_Q15[15:0] : load.collision;
    assign wa       = clamp_w(speed_smoothing);
    assign wb       = clamp_w(turn_smoothing);
    assign med_now  = median3(ring_reg[0], ring_reg[1], ring_reg[2]);
    assign scaled   = acc_reg[33:15];

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (ctrl.mul)
            ossc_pkg::M_GAIN_STEER: begin
                op_a = signed'({2'b00, turn_gain});
                op_b = 17'(steer_reg);
            end
            ossc_pkg::M_LIMIT_MED: begin
                op_a = signed'({2'b00, speed_limit});
                op_b = signed'(ossc_pkg::ONE_Q15 - {1'b0, med_reg});
            end
            ossc_pkg::M_TURN_WB: begin
                op_a = signed'(ossc_pkg::ONE_Q15 - wb);
                op_b = 17'(turn_reg);
            end
            ossc_pkg::M_TGT_B: begin
                op_a = signed'(wb);
                op_b = 17'(tgt_reg);
            end
            ossc_pkg::M_SPEED_WA: begin
                op_a = signed'(ossc_pkg::ONE_Q15 - wa);
                op_b = signed'({2'b00, speed_reg});
            end
            ossc_pkg::M_TGT_A: begin
                op_a = signed'(wa);
                op_b = 17'(tgt_reg);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // filter state and ring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ossc_pkg::RING_DEPTH; i++) begin
                ring_reg[i] <= '0;
            end
            slot_reg  <= '0;
            speed_reg <= '0;
            turn_reg  <= '0;
        end else begin
            if (load.write_ring) begin
                ring_reg[slot_reg] <= coll_sat;
                slot_reg <= (slot_reg == SLOT_W'(ossc_pkg::RING_DEPTH - 1)) ? '0 :
                            slot_reg + SLOT_W'(1);
            end
            if (step_en && ctrl.dst == ossc_pkg::D_TURN) begin
                turn_reg <= sat_yaw(scaled);
            end
            if (step_en && ctrl.dst == ossc_pkg::D_SPEED) begin
                speed_reg <= sat_speed(scaled);
            end
        end
    end

    // scratch registers of the sequenced datapath
    always_ff @(posedge aclk) begin
        if (load.latch_steer) begin
            steer_reg <= load.steer;
        end
        if (step_en) begin
            prod_reg <= op_a * op_b;
            case (ctrl.acc)
                ossc_pkg::ACC_LOAD: acc_reg <= prod_reg + signed'(ossc_pkg::HALF_Q15);
                ossc_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg;
                default:            acc_reg <= acc_reg;
            endcase
            case (ctrl.dst)
                ossc_pkg::D_MED:     med_reg <= med_now;
                ossc_pkg::D_TGT_SAT: tgt_reg <= sat_yaw(scaled);
                ossc_pkg::D_TGT:     tgt_reg <= scaled[15:0];
                default: begin
                end
            endcase
        end
    end

    assign speed_out = speed_reg;
    assign turn_out  = turn_reg;

endmodule

`default_nettype wire

// ----- hdl/ossc_chk.sv -----
// Port-level checker for the conditioner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ossc_chk (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [2:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a stop setpoint carries all-zero values
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 48'd0)
        else $error("stop setpoint with nonzero fields");

    // yaw command stays inside its limit
    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[30:15]) <= ossc_pkg::YAW_LIMIT &&
                     $signed(m_tdata[30:15]) >= -ossc_pkg::YAW_LIMIT)
        else $error("yaw rate out of range");

    // an unlocked or stopping item occupies the sequencer
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[1:0] == ossc_pkg::MODE_UNLOCKED ||
                                 s_tuser[1:0] == ossc_pkg::MODE_STOPPING)
        |=> !s_tready)
        else $error("new item taken while sequencer busy");

    // an idle item produces no result
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[1:0] == ossc_pkg::MODE_IDLE && !m_tvalid
        |=> !m_tvalid)
        else $error("result emitted for idle item");

endmodule

bind obstacle_speed_steer_conditioner ossc_chk u_ossc_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
